// ===== hdl/mbdl_pkg.sv =====
// mbdl_pkg: shared types and codes for the multi-button debounce/lockout unit
// no dependencies; used by mbdl_lane and the top level
`default_nettype none

package mbdl_pkg;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // key status codes
  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_PRESSED = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int LOCKOUT_W  = 16;
  localparam int KEY_W      = 8;

  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 16'd20;
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RST   = 16'd10;
  localparam logic                  ACTIVE_RST    = 1'b1;

  // per-lane control from the top level
  typedef struct packed {
    logic tick;     // tick executes this cycle
    logic level;    // sampled raw level of this button
    logic blocked;  // lockout running or a lower button pressed
    logic clear;    // read-to-clear of the press flag
  } lane_ctl_t;

  // per-lane status back to the top level
  typedef struct packed {
    logic cand;     // would press if not blocked
    logic flag;     // press flag
  } lane_stat_t;

endpackage

`default_nettype wire

// ===== hdl/multi_button_debounce_lockout_unit.sv =====
// multi_button_debounce_lockout_unit: top level, input/output registers, config,
// shared lockout counter; depends on mbdl_pkg, mbdl_lane, mbdl_merge
//
// Usage:
//   in_*   : one item per transfer. command 0 is a sample tick carrying all
//            button levels; command 1 reads and clears the press flag of
//            button in_key_index.
//   out_*  : one transfer per read command, out_key_status 0 idle, 1 pressed
//            since last read, 2 invalid index. Ticks give no result.
//   cfg_*  : register writes, always ready; index 0 debounce threshold,
//            1 lockout ticks, 2 active level. Other indexes are ignored.
// Timing: an item is captured on its transfer and processed in the next
//   cycle by all button lanes in parallel, unless a read must wait for the
//   output register; no new item is taken until the held one is processed.
//   A read result is registered in the cycle after its processing cycle.
// The output register decouples the sides: a tick passes while a result is
//   held; a read waits in the input register while out_stall holds the
//   previous result, which keeps in_stall high.
// Reset: counters and flags clear, last levels read as all ones, lockout is
//   zero, configuration registers take their default values.
`default_nettype none

module multi_button_debounce_lockout_unit #(
  parameter int NUM_BUTTONS  = 2,
  parameter int COUNTER_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_command,
  input  wire [NUM_BUTTONS-1:0]               in_button_levels,
  input  wire [mbdl_pkg::KEY_W-1:0]           in_key_index,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_key_status,
  // configuration
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [mbdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [mbdl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int LW = mbdl_pkg::LOCKOUT_W;

  // configuration registers
  logic [mbdl_pkg::CFG_DATA_W-1:0] thr_r;
  logic [LW-1:0]                   ticks_r;
  logic                            active_r;

  // item holding register
  logic                            busy_r;
  logic                            cmd_r;
  logic [NUM_BUTTONS-1:0]          lvl_r;
  logic [mbdl_pkg::KEY_W-1:0]      key_r;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r;

  logic [LW-1:0]                   lockout_r, lockout_nxt, lockout_dec;

  logic                            in_xfer, exec, exec_tick, exec_read;
  logic                            lock_nz, ticks_nz, any_press, key_ok, hit;
  logic [NUM_BUTTONS-1:0]          cand, blocked, press_vec;
  logic [1:0]                      status_nxt;

  mbdl_pkg::lane_ctl_t             ctl  [NUM_BUTTONS];
  mbdl_pkg::lane_stat_t            stat [NUM_BUTTONS];

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r;
  assign in_xfer   = in_valid && !in_stall;

  // a read needs the result register free or leaving this cycle
  assign exec      = busy_r && ((cmd_r == mbdl_pkg::CMD_TICK) || !out_valid_r || !out_stall);
  assign exec_tick = exec && (cmd_r == mbdl_pkg::CMD_TICK);
  assign exec_read = exec && (cmd_r == mbdl_pkg::CMD_READ);

  assign lockout_dec = (lockout_r != '0) ? lockout_r - LW'(1) : lockout_r;
  assign lock_nz     = (lockout_dec != '0);
  assign ticks_nz    = (ticks_r != '0);

  genvar b;
  generate
    for (b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      assign cand[b]        = stat[b].cand;
      assign press_vec[b]   = cand[b] && !blocked[b];
      assign ctl[b].tick    = exec_tick;
      assign ctl[b].level   = lvl_r[b];
      assign ctl[b].blocked = blocked[b];
      assign ctl[b].clear   = exec_read && (key_r == mbdl_pkg::KEY_W'(b));

      mbdl_lane #(
        .COUNTER_BITS (COUNTER_BITS)
      ) u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl[b]),
        .threshold    (thr_r),
        .active_level (active_r),
        .stat         (stat[b])
      );
    end
  endgenerate

  mbdl_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .cand      (cand),
    .lock_nz   (lock_nz),
    .ticks_nz  (ticks_nz),
    .blocked   (blocked),
    .any_press (any_press)
  );

  assign lockout_nxt = exec_tick ? (any_press ? ticks_r : lockout_dec) : lockout_r;

  // read path
  assign key_ok = (key_r < mbdl_pkg::KEY_W'(NUM_BUTTONS));

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hit = hit | (stat[i].flag & (key_r == mbdl_pkg::KEY_W'(i)));
    end
  end

  assign status_nxt = !key_ok ? mbdl_pkg::STATUS_INVALID :
                      hit     ? mbdl_pkg::STATUS_PRESSED : mbdl_pkg::STATUS_IDLE;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_read) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lockout_r   <= '0;
      thr_r       <= mbdl_pkg::THRESHOLD_RST;
      ticks_r     <= mbdl_pkg::LOCKOUT_RST;
      active_r    <= mbdl_pkg::ACTIVE_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      lockout_r   <= lockout_nxt;
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mbdl_pkg::CFG_THRESHOLD: thr_r    <= cfg_wdata;
          mbdl_pkg::CFG_LOCKOUT:   ticks_r  <= LW'(cfg_wdata);
          mbdl_pkg::CFG_ACTIVE:    active_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_command;
      lvl_r <= in_button_levels;
      key_r <= in_key_index;
    end
    if (exec_read) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_status = out_status_r;

`ifndef ASSERT_OFF
  // a nonzero reload lets only the lowest candidate press
  a_one_press: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_tick && ticks_nz) |-> $onehot0(press_vec))
    else $error("more than one press in a tick with lockout enabled");

  // no press while the lockout is still running
  a_no_press_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_tick && lock_nz) |-> (press_vec == '0))
    else $error("press during lockout");

  // an executed read always produces a result
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_read) |=> out_valid_r)
    else $error("read executed without a result");

  // out-of-range index reports invalid
  a_invalid_key: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_read && !key_ok) |=> (out_status_r == mbdl_pkg::STATUS_INVALID))
    else $error("invalid index not reported");

  // a read never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !exec_read)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/mbdl_lane.sv =====
// mbdl_lane: debounce core for one button (stable counter, last level, press flag)
// depends on mbdl_pkg
`default_nettype none

module mbdl_lane #(
  parameter int COUNTER_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire mbdl_pkg::lane_ctl_t            ctl,
  input  wire [mbdl_pkg::CFG_DATA_W-1:0]      threshold,
  input  wire                                 active_level,
  output mbdl_pkg::lane_stat_t                stat
);

  localparam int CMP_W = (COUNTER_BITS > mbdl_pkg::CFG_DATA_W) ?
                         COUNTER_BITS : mbdl_pkg::CFG_DATA_W;

  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                    prev_r, prev_nxt;
  logic                    flag_r, flag_nxt;
  logic                    same, counting, press;

  assign same     = (ctl.level == prev_r);
  assign counting = same && (ctl.level == active_level);
  // saturating increment
  assign cnt_inc  = (cnt_r == {COUNTER_BITS{1'b1}}) ? cnt_r : cnt_r + COUNTER_BITS'(1);

  assign stat.cand = counting && (CMP_W'(cnt_inc) > CMP_W'(threshold));
  assign stat.flag = flag_r;
  assign press     = stat.cand && !ctl.blocked;

  always_comb begin
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    flag_nxt = flag_r;
    if (ctl.tick) begin
      prev_nxt = ctl.level;
      if (!same) begin
        cnt_nxt = '0;
      end else if (counting && !ctl.blocked) begin
        cnt_nxt = press ? '0 : cnt_inc;
      end
      if (press) begin
        flag_nxt = 1'b1;
      end
    end else if (ctl.clear) begin
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      prev_r <= 1'b1;
      flag_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mbdl_merge.sv =====
// mbdl_merge: combines lane candidates into per-lane blocking (lower index wins if the reload is nonzero)
// uses nothing from mbdl_pkg; its outputs are used by the top level
`default_nettype none

module mbdl_merge #(
  parameter int NUM_BUTTONS = 2
) (
  input  wire [NUM_BUTTONS-1:0] cand,
  input  wire                   lock_nz,   // lockout nonzero after decrement
  input  wire                   ticks_nz,  // a press reloads a nonzero lockout
  output logic [NUM_BUTTONS-1:0] blocked,
  output logic                   any_press
);

  genvar b;
  generate
    for (b = 0; b < NUM_BUTTONS; b++) begin : g_blk
      if (b == 0) begin : g_first
        assign blocked[b] = lock_nz;
      end else begin : g_rest
        // the first candidate below presses and reloads the lockout
        assign blocked[b] = lock_nz || (ticks_nz && (|cand[b-1:0]));
      end
    end
  endgenerate

  assign any_press = !lock_nz && (|cand);

endmodule

`default_nettype wire
